// ----- hdl/esc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, constants and lookup functions for the epoch-seconds to
// calendar converter
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int NUM_STAGES = 7;

   // reciprocal constants for division by multiplication
   localparam logic [25:0] DAY_RECIP   = 26'd50903317; // 2^35 / 675, rounded up
   localparam logic [16:0] SPAN_RECIP  = 17'd91868;    // 2^27 / 1461, rounded up
   localparam logic [17:0] HOUR_RECIP  = 18'd149131;   // 2^29 / 3600, rounded up
   localparam logic [12:0] MIN_RECIP   = 13'd4370;     // 2^18 / 60, rounded up
   localparam logic [12:0] WEEK_RECIP  = 13'd4682;     // 2^15 / 7, rounded up

   localparam logic [31:0] SEC_PER_DAY    = 32'd86400;
   localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
   localparam logic [11:0] SEC_PER_MIN    = 12'd60;
   localparam logic [15:0] DAYS_PER_SPAN  = 16'd1461;
   localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;
   localparam logic [15:0] DAYS_TWO_YEARS = 16'd730;
   localparam logic [10:0] LEAP_HEAD_DAYS = 11'd60;
   localparam logic [10:0] LEAP_DAY_IDX   = 11'd59;
   localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
   localparam logic [11:0] SPAN_YEAR      = 12'd1972;
   localparam logic [11:0] YEAR_2000      = 12'd2000;
   localparam logic [11:0] YEAR_2100      = 12'd2100;
   localparam logic [11:0] CENTURY_BASE   = 12'd19;  // z/100 for z in 1969..1999
   localparam logic [11:0] QUAD_CENT_BASE = 12'd4;   // z/400 for z in 1969..1999
   localparam logic [11:0] WEEK_OFFSET    = 12'd4;
   localparam logic [11:0] MARCH_ADJUST   = 12'd2;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  MONTH_MAR      = 4'd3;
   localparam logic [4:0]  LEAP_DAY_NUM   = 5'd29;

   // per-stage pipeline payload; each stage fills in more of it
   typedef struct packed {
      logic [31:0] t;
      logic [15:0] day_num;
      logic [16:0] secs;
      logic        early;
      logic [15:0] qdays;
      logic [5:0]  span;
      logic [10:0] span_day;
      logic [4:0]  hour;
      logic [11:0] rem;
      logic [11:0] year;
      logic [8:0]  doy;
      logic        leap29;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [11:0] wsum;
      logic [2:0]  wday;
   } stage_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } ctl_type;

   // first day of each month in a plain year, index 0 is january
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] r;
      case (idx)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         4'd12:   r = 9'd365;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // 23*m/9 term of the weekday formula
   function automatic logic [4:0] month_term(input logic [3:0] m);
      logic [4:0] r;
      case (m)
         4'd1:    r = 5'd2;
         4'd2:    r = 5'd5;
         4'd3:    r = 5'd7;
         4'd4:    r = 5'd10;
         4'd5:    r = 5'd12;
         4'd6:    r = 5'd15;
         4'd7:    r = 5'd17;
         4'd8:    r = 5'd20;
         4'd9:    r = 5'd23;
         4'd10:   r = 5'd25;
         4'd11:   r = 5'd28;
         4'd12:   r = 5'd30;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/esc_pipe_ctl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pipe_ctl
// valid bits and per-stage load enables for the converter pipeline; a stage
// loads when it is empty or the stage after it moves on
// ----------------------------------------------------------------------------
module esc_pipe_ctl
   import esc_pkg::*;
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    in_valid,
   input  wire  logic    out_ready,
   output       ctl_type ctl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = adv;
   assign ctl.valid = valid_ff;

endmodule
`default_nettype wire

// ----- hdl/epoch_seconds_to_calendar.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts an unsigned 32-bit count of seconds since 1970-01-01 into year,
// month, day, time of day and weekday (four-year leap rule for the date)
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   seconds_since_epoch
//  rsp_      out        rsp_valid/rsp_ready   cal_year .. weekday
//
//  one transaction enters per cycle while req_ready is high; the accepting
//  edge loads the first of seven register stages, and each result passes
//  through all seven in order before it shows on rsp_
//  each stage holds while the stage after it is full and stalled, so a
//  stall on rsp_ clears bubbles first and then backs up into req_ready
//  synchronous reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
   import esc_pkg::*;
(
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output       logic        req_ready,
   input  wire  logic [31:0] req_seconds_since_epoch,
   output       logic        rsp_valid,
   input  wire  logic        rsp_ready,
   output       logic [11:0] rsp_cal_year,
   output       logic [3:0]  rsp_cal_month,
   output       logic [4:0]  rsp_day_of_month,
   output       logic [4:0]  rsp_hour_of_day,
   output       logic [5:0]  rsp_minute_of_hour,
   output       logic [5:0]  rsp_sec_of_minute,
   output       logic [2:0]  rsp_weekday
);

   ctl_type   ctl;
   stage_type pipe_ff [NUM_STAGES];
   stage_type pipe_in [NUM_STAGES];

   // products, each registered before anything multiplies its result again
   logic [50:0] prod0;
   logic [32:0] prod1;
   logic [34:0] prod2;
   logic [24:0] prod4;
   logic [24:0] prod6;

   // date split temporaries
   logic [11:0] base_year;
   logic [10:0] vday;
   logic [1:0]  yoff;
   logic [3:0]  mon;
   logic [11:0] zyear;
   logic [11:0] c100;
   logic [11:0] c400;
   logic [11:0] kterm;
   logic [9:0]  q7;
   logic [12:0] mul7;

   esc_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .ctl       (ctl)
   );

   always_comb begin
      // stage 0: day number = t / 86400 = (t >> 7) / 675
      pipe_in[0]         = '0;
      pipe_in[0].t       = req_seconds_since_epoch;
      prod0              = 51'(req_seconds_since_epoch[31:7]) * 51'(DAY_RECIP);
      pipe_in[0].day_num = prod0[50:35];

      // stage 1: seconds within the day, four-year span index
      pipe_in[1]       = pipe_ff[0];
      pipe_in[1].secs  = 17'(pipe_ff[0].t - (32'(pipe_ff[0].day_num) * SEC_PER_DAY));
      pipe_in[1].early = pipe_ff[0].day_num < DAYS_TWO_YEARS;
      pipe_in[1].qdays = pipe_ff[0].day_num - DAYS_TWO_YEARS;
      prod1            = 33'(pipe_in[1].qdays) * 33'(SPAN_RECIP);
      pipe_in[1].span  = prod1[32:27];

      // stage 2: hour, day within the span
      pipe_in[2]          = pipe_ff[1];
      prod2               = 35'(pipe_ff[1].secs) * 35'(HOUR_RECIP);
      pipe_in[2].hour     = prod2[33:29];
      pipe_in[2].span_day = 11'(pipe_ff[1].qdays - 16'(16'(pipe_ff[1].span) * DAYS_PER_SPAN));

      // stage 3: seconds within the hour, year and day of year
      pipe_in[3]     = pipe_ff[2];
      pipe_in[3].rem = 12'(pipe_ff[2].secs - 17'(17'(pipe_ff[2].hour) * SEC_PER_HOUR));
      base_year      = SPAN_YEAR + {4'b0, pipe_ff[2].span, 2'b00};
      vday           = pipe_ff[2].span_day - 11'd1;
      yoff           = 2'(32'(vday >= 11'(DAYS_PER_YEAR))
                        + 32'(vday >= 11'(DAYS_TWO_YEARS))
                        + 32'(vday >= 11'(DAYS_TWO_YEARS + DAYS_PER_YEAR)));
      pipe_in[3].leap29 = 1'b0;
      if (pipe_ff[2].early) begin
         // 1970 and 1971 are plain years ahead of the first span
         if (pipe_ff[2].day_num >= DAYS_PER_YEAR) begin
            pipe_in[3].year = EPOCH_YEAR + 12'd1;
            pipe_in[3].doy  = 9'(pipe_ff[2].day_num - DAYS_PER_YEAR);
         end else begin
            pipe_in[3].year = EPOCH_YEAR;
            pipe_in[3].doy  = pipe_ff[2].day_num[8:0];
         end
      end else if (pipe_ff[2].span_day < LEAP_HEAD_DAYS) begin
         // january and february of the leap year, leap day included
         pipe_in[3].year   = base_year;
         pipe_in[3].doy    = pipe_ff[2].span_day[8:0];
         pipe_in[3].leap29 = pipe_ff[2].span_day == LEAP_DAY_IDX;
      end else begin
         // leap day dropped, rest split into plain years
         pipe_in[3].year = base_year + 12'(yoff);
         pipe_in[3].doy  = 9'(vday - 11'(11'(yoff) * 11'(DAYS_PER_YEAR)));
      end

      // stage 4: minute, month and day of month
      pipe_in[4]        = pipe_ff[3];
      prod4             = 25'(pipe_ff[3].rem) * 25'(MIN_RECIP);
      pipe_in[4].minute = prod4[23:18];
      mon               = 4'd1;
      for (int i = 1; i < 12; i++) begin
         if (pipe_ff[3].doy >= month_start(4'(i))) begin
            mon = mon + 4'd1;
         end
      end
      if (pipe_ff[3].leap29) begin
         pipe_in[4].month = MONTH_FEB;
         pipe_in[4].day   = LEAP_DAY_NUM;
      end else begin
         pipe_in[4].month = mon;
         pipe_in[4].day   = 5'(pipe_ff[3].doy - month_start(mon - 4'd1) + 9'd1);
      end

      // stage 5: second, weekday sum
      pipe_in[5]        = pipe_ff[4];
      pipe_in[5].second = 6'(pipe_ff[4].rem - 12'(12'(pipe_ff[4].minute) * SEC_PER_MIN));
      zyear             = (pipe_ff[4].month < MONTH_MAR) ? pipe_ff[4].year - 12'd1
                                                         : pipe_ff[4].year;
      // z stays within 1969..2106, so century terms reduce to compares
      c100  = CENTURY_BASE + 12'(zyear >= YEAR_2000) + 12'(zyear >= YEAR_2100);
      c400  = QUAD_CENT_BASE + 12'(zyear >= YEAR_2000);
      kterm = (pipe_ff[4].month >= MONTH_MAR) ? MARCH_ADJUST : 12'd0;
      pipe_in[5].wsum = 12'(month_term(pipe_ff[4].month)) + 12'(pipe_ff[4].day)
                      + WEEK_OFFSET + pipe_ff[4].year + {2'b00, zyear[11:2]}
                      - c100 + c400 - kterm;

      // stage 6: weekday = sum mod 7
      pipe_in[6]      = pipe_ff[5];
      prod6           = 25'(pipe_ff[5].wsum) * 25'(WEEK_RECIP);
      q7              = prod6[24:15];
      mul7            = {q7, 3'b000} - {3'b000, q7};
      pipe_in[6].wday = 3'(13'(pipe_ff[5].wsum) - mul7);
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (ctl.load[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign req_ready          = ctl.load[0];
   assign rsp_valid          = ctl.valid[NUM_STAGES-1];
   assign rsp_cal_year       = pipe_ff[NUM_STAGES-1].year;
   assign rsp_cal_month      = pipe_ff[NUM_STAGES-1].month;
   assign rsp_day_of_month   = pipe_ff[NUM_STAGES-1].day;
   assign rsp_hour_of_day    = pipe_ff[NUM_STAGES-1].hour;
   assign rsp_minute_of_hour = pipe_ff[NUM_STAGES-1].minute;
   assign rsp_sec_of_minute  = pipe_ff[NUM_STAGES-1].second;
   assign rsp_weekday        = pipe_ff[NUM_STAGES-1].wday;

endmodule
`default_nettype wire

// ----- verif/epoch_seconds_to_calendar_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// drives second counts into the calendar converter through its ready/valid
// request channel and checks every calendar result against a local
// prediction, under random gaps on both sides and long output stalls
// ----------------------------------------------------------------------------

localparam int unsigned DAY_SEC      = 86400;
localparam int unsigned YEAR_SEC     = 365 * DAY_SEC;
localparam int unsigned SPAN_SEC     = 1461 * DAY_SEC;
localparam int unsigned LEAP_END_SEC = 60 * DAY_SEC;
localparam int unsigned SPAN_ORIGIN  = 2 * YEAR_SEC;

typedef struct packed {
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [2:0]  wday;
} civil_time_type;

// calendar fields of a second count, four-year leap rule for the date,
// gregorian century terms only in the weekday sum
function automatic civil_time_type civil_time_of(input logic [31:0] secs);
   int unsigned month_first[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                    334, 365};
   int unsigned year, in_year, in_span, in_month, in_day, lim, month, i, z, k, wsum;
   bit          leap_head, found;
   civil_time_type r;
   leap_head = 1'b0;
   if (secs < SPAN_ORIGIN) begin
      year    = 1970 + secs / YEAR_SEC;
      in_year = secs % YEAR_SEC;
   end else begin
      in_span = (secs - SPAN_ORIGIN) % SPAN_SEC;
      year    = 1972 + 4 * ((secs - SPAN_ORIGIN) / SPAN_SEC);
      if (in_span <= LEAP_END_SEC) begin
         leap_head = 1'b1;
         in_year   = in_span;
      end else begin
         year    = year + (in_span - DAY_SEC) / YEAR_SEC;
         in_year = (in_span - DAY_SEC) % YEAR_SEC;
      end
   end
   // first month whose end lies past the offset into the year
   month = 12;
   found = 1'b0;
   for (i = 1; i <= 12; i++) begin
      lim = month_first[i] * DAY_SEC;
      if (i == 2 && leap_head) lim = lim + DAY_SEC;
      if (!found && lim > in_year) begin
         month = i;
         found = 1'b1;
      end
   end
   in_month = in_year - month_first[month - 1] * DAY_SEC;
   if (month == 3 && leap_head) in_month = in_year - LEAP_END_SEC;
   in_day = in_month % DAY_SEC;
   z      = (month < 3) ? year - 1 : year;
   k      = (month >= 3) ? 2 : 0;
   r.year   = year[11:0];
   r.month  = month[3:0];
   r.day    = 5'(in_month / DAY_SEC + 1);
   r.hour   = 5'(in_day / 3600);
   r.minute = 6'((in_day % 3600) / 60);
   r.second = 6'(in_day % 60);
   wsum     = (23 * month) / 9 + r.day + 4 + year + z / 4 - z / 100 + z / 400 - k;
   r.wday   = 3'(wsum % 7);
   return r;
endfunction

class calendar_scoreboard;
   civil_time_type expected_dates[$];
   logic [31:0]    pending_seconds[$];
   int unsigned    errors;

   function new();
      errors = 0;
   endfunction

   function int pending();
      return expected_dates.size();
   endfunction

   function void note_request(input logic [31:0] secs);
      expected_dates.push_back(civil_time_of(secs));
      pending_seconds.push_back(secs);
   endfunction

   task report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task compare_field(input string name, input logic [31:0] secs,
                      input int unsigned got, input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("seconds %0d: %s is %0d, expected %0d",
                                   secs, name, got, want));
   endtask

   task check_result(input civil_time_type got);
      civil_time_type want;
      logic [31:0]    secs;
      if (expected_dates.size() == 0) begin
         report_mismatch($sformatf("result %0d-%0d-%0d with no transaction pending",
                                   got.year, got.month, got.day));
         return;
      end
      want = expected_dates.pop_front();
      secs = pending_seconds.pop_front();
      compare_field("cal_year", secs, got.year, want.year);
      compare_field("cal_month", secs, got.month, want.month);
      compare_field("day_of_month", secs, got.day, want.day);
      compare_field("hour_of_day", secs, got.hour, want.hour);
      compare_field("minute_of_hour", secs, got.minute, want.minute);
      compare_field("sec_of_minute", secs, got.second, want.second);
      compare_field("weekday", secs, got.wday, want.wday);
   endtask

   task report_leftovers();
      if (expected_dates.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));
   endtask
endclass

module epoch_seconds_to_calendar_tb;
   import esc_pkg::*;

   // directed corners: field extremes, the first two plain years, the leap
   // day and the start of march, the four-year-rule 2100 leap day, top of range
   localparam logic [31:0] CORNER_SECONDS [25] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd63071999, 32'd63072000,
      32'd68083200, 32'd68169600, 32'd68255999, 32'd68256000,
      32'd94694399, 32'd94694400,
      32'd951782400, 32'd951868800, 32'd4107542400, 32'd4107628800,
      32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF
   };
   localparam int PHASE_ITEMS = 383;
   localparam int HOLD_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_seconds_since_epoch = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_cal_year;
   logic [3:0]  rsp_cal_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_sec_of_minute;
   logic [2:0]  rsp_weekday;

   calendar_scoreboard sb;
   civil_time_type     seen_date;

   // idle odds in percent per cycle, set per phase by the main sequence
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   // long output stalls: main asks, the receiver process counts them out
   int unsigned holds_requested = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;

   always #5 clock = ~clock;

   epoch_seconds_to_calendar dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_seconds_since_epoch (req_seconds_since_epoch),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_cal_year            (rsp_cal_year),
      .rsp_cal_month           (rsp_cal_month),
      .rsp_day_of_month        (rsp_day_of_month),
      .rsp_hour_of_day         (rsp_hour_of_day),
      .rsp_minute_of_hour      (rsp_minute_of_hour),
      .rsp_sec_of_minute       (rsp_sec_of_minute),
      .rsp_weekday             (rsp_weekday)
   );

   // receiver: random back-pressure, or a long hold when one is asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_served != holds_requested) begin
         holds_served = holds_served + 1;
         hold_left    = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result monitor; outputs are stable mid-cycle, so a transaction seen
   // here completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_date.year   = rsp_cal_year;
         seen_date.month  = rsp_cal_month;
         seen_date.day    = rsp_day_of_month;
         seen_date.hour   = rsp_hour_of_day;
         seen_date.minute = rsp_minute_of_hour;
         seen_date.second = rsp_sec_of_minute;
         seen_date.wday   = rsp_weekday;
         sb.check_result(seen_date);
      end
   end

   // one request transaction, after a random number of idle cycles;
   // req_ready is sampled mid-cycle to stay clear of the edge
   task automatic send_seconds(input logic [31:0] secs);
      bit taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_seconds_since_epoch <= secs;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      sb.note_request(secs);
   endtask

   // drop valid, wait for every pending result, then let the pipe settle
   task automatic drain_results();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (NUM_STAGES + 5) @(posedge clock);
   endtask

   // random second count; many land near span, leap-day and day edges
   function automatic logic [31:0] pick_seconds();
      logic [31:0] base;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5: begin
            base = SPAN_ORIGIN + $urandom_range(0, 33) * SPAN_SEC;
            case ($urandom_range(0, 5))
               0:       base = base;
               1:       base = base + 59 * DAY_SEC;
               2:       base = base + LEAP_END_SEC;
               3:       base = base + 366 * DAY_SEC;
               4:       base = base + 731 * DAY_SEC;
               default: base = base + 1096 * DAY_SEC;
            endcase
            return base + $urandom_range(0, 6) - 32'd3;
         end
         6, 7: return $urandom_range(0, 49710) * DAY_SEC + $urandom_range(0, 4) - 32'd2;
         8:    return $urandom_range(0, SPAN_ORIGIN + 2 * DAY_SEC);
         default: return 32'hFFFFFFFF - $urandom_range(0, 200000000);
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners with both sides idling
      send_idle_pct = 33;
      recv_idle_pct = 50;
      foreach (CORNER_SECONDS[i]) send_seconds(CORNER_SECONDS[i]);
      drain_results();

      // random phase one: sender idles less than receiver, one long hold
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == 150) holds_requested = holds_requested + 1;
         send_seconds(pick_seconds());
      end
      // sender pauses here until every result is back
      drain_results();

      // random phase two: the other way round
      send_idle_pct = 50;
      recv_idle_pct = 33;
      for (int n = 0; n < PHASE_ITEMS; n++) send_seconds(pick_seconds());
      drain_results();

      // random phase three: back-to-back, with a hold to fill the pipe
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == 100) holds_requested = holds_requested + 1;
         send_seconds(pick_seconds());
      end
      drain_results();

      sb.report_leftovers();
      if (sb.errors == 0) begin
         $display("** epoch_seconds_to_calendar: PASSED **");
      end else begin
         $display("** epoch_seconds_to_calendar: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("** epoch_seconds_to_calendar: FAILED **");
      $finish;
   end

endmodule
